/* hw/rtl/i2cmbe_pkg.sv */
// Package for the I2C master byte engine: phase and action codes, the result
// record and helpers for the engine, and port widths shared with its checker.
// Depends on nothing.
package i2cmbe_pkg;

  localparam int unsigned BitsPerByte     = 8;
  localparam logic [7:0]  ResetSetupWait  = 8'd3;
  localparam logic [7:0]  ResetPhaseWait  = 8'd5;
  localparam int unsigned CfgAddrWidth    = 3;
  localparam int unsigned CfgDataWidth    = 32;

  // Register index, taken from byte address bit 2.
  typedef enum logic {
    CFG_DATA_SETUP_WAIT = 1'b0,
    CFG_PHASE_WAIT      = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_STOP_A  = 4'd3,
    PH_STOP_B  = 4'd4,
    PH_STOP_C  = 4'd5,
    PH_WR_LOW  = 4'd6,
    PH_WR_HIGH = 4'd7,
    PH_WR_ACK  = 4'd8,
    PH_RD_HIGH = 4'd9,
    PH_RD_LOW  = 4'd10,
    PH_RD_ACKH = 4'd11,
    PH_RD_ACKL = 4'd12
  } phase_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] read_byte;
    logic       rejected;
  } result_t;

  // A programmed wait of zero still lasts one tick.
  function automatic logic [7:0] load_wait(input logic [7:0] ticks);
    load_wait = (ticks == 8'd0) ? 8'd1 : ticks;
  endfunction

endpackage

/* hw/rtl/i2c_master_byte_engine_unit.sv */
// I2C master byte engine top level: tick sequencer, configuration registers
// and a two-entry result buffer. Depends on i2cmbe_pkg.
//
// Usage: every input item is one bus timing tick (typically one microsecond).
// The item carries an action (tick only, start, stop, write byte, read byte),
// the byte to write, the ACK choice for reads and the sampled SDA level.
// Each accepted item yields exactly one result item with the SCL/SDA drive
// levels after that tick, busy and done flags, the last acknowledge status,
// the last received byte and a flag for a command refused while busy.
// An accepted item's result is registered in the head entry of the buffer,
// or in the skid entry while the head still waits. Throughput is one item per
// cycle while in_ready is high, set by the sequencer updating at accept.
// A two-entry result buffer sits behind the sequencer, so the block keeps
// taking items while one finished result waits; in_ready drops only when both
// entries are full, and it does not depend on out_ready combinationally.
// The waits data_setup_wait and phase_wait are written through the APB-style
// port at byte addresses 0 and 4; the user writes them only while the block
// is idle, which the block itself does not enforce. Synchronous reset returns
// the sequencer to idle with both lines released, clears flags and the
// received byte, restores the waits to 3 and 5 and empties the result buffer.
module i2c_master_byte_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_action,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_send_ack,
  input  logic                                 in_sda_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_scl_level,
  output logic                                 out_sda_level,
  output logic                                 out_busy_res,
  output logic                                 out_done_res,
  output logic                                 out_nack_seen,
  output logic [7:0]                           out_read_byte,
  output logic                                 out_rejected,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2cmbe_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [i2cmbe_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [i2cmbe_pkg::CfgDataWidth-1:0]  prdata,
  output logic                                 pready
);

  // Configuration registers.
  logic [7:0] setup_wait_r;
  logic [7:0] phase_wait_r;
  logic       cfg_wr;
  i2cmbe_pkg::cfg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = i2cmbe_pkg::cfg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_wait_r <= i2cmbe_pkg::ResetSetupWait;
      phase_wait_r <= i2cmbe_pkg::ResetPhaseWait;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        i2cmbe_pkg::CFG_DATA_SETUP_WAIT: setup_wait_r <= pwdata[7:0];
        i2cmbe_pkg::CFG_PHASE_WAIT:      phase_wait_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      i2cmbe_pkg::CFG_DATA_SETUP_WAIT:
        prdata = {{(i2cmbe_pkg::CfgDataWidth-8){1'b0}}, setup_wait_r};
      i2cmbe_pkg::CFG_PHASE_WAIT:
        prdata = {{(i2cmbe_pkg::CfgDataWidth-8){1'b0}}, phase_wait_r};
      default:
        prdata = '0;
    endcase
  end

  // Sequencer state.
  i2cmbe_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       nack_r, nack_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done;
  logic       rej;

  logic [7:0] wait_dec;
  logic [3:0] bit_inc;
  logic [7:0] setup_ld;
  logic [7:0] phase_ld;
  logic       accept;

  assign accept   = in_valid & in_ready;
  assign wait_dec = (wait_r != 8'd0) ? (wait_r - 8'd1) : 8'd0;
  assign bit_inc  = bit_idx_r + 4'd1;
  assign setup_ld = i2cmbe_pkg::load_wait(setup_wait_r);
  assign phase_ld = i2cmbe_pkg::load_wait(phase_wait_r);

  // One tick of the sequencer: either launch a command from idle, or count
  // down the current phase and step to the next one when the count expires.
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    wait_nxt    = wait_r;
    shift_nxt   = shift_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    nack_nxt    = nack_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    rej         = 1'b0;

    if (phase_r == i2cmbe_pkg::PH_IDLE) begin
      unique case (in_action)
        i2cmbe_pkg::ACT_START: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = i2cmbe_pkg::PH_START_A;
          wait_nxt  = phase_ld;
        end
        i2cmbe_pkg::ACT_STOP: begin
          sda_nxt   = 1'b0;
          scl_nxt   = 1'b0;
          phase_nxt = i2cmbe_pkg::PH_STOP_A;
          wait_nxt  = phase_ld;
        end
        i2cmbe_pkg::ACT_WRITE: begin
          shift_nxt   = in_data_byte;
          bit_idx_nxt = 4'd0;
          scl_nxt     = 1'b0;
          sda_nxt     = in_data_byte[7];
          phase_nxt   = i2cmbe_pkg::PH_WR_LOW;
          wait_nxt    = setup_ld;
        end
        i2cmbe_pkg::ACT_READ: begin
          shift_nxt   = 8'd0;
          bit_idx_nxt = 4'd0;
          ack_nxt     = in_send_ack;
          scl_nxt     = 1'b1;
          sda_nxt     = 1'b1;
          phase_nxt   = i2cmbe_pkg::PH_RD_HIGH;
          wait_nxt    = phase_ld;
        end
        default: ;  // tick only and unused codes
      endcase
    end else begin
      rej      = (in_action >= i2cmbe_pkg::ACT_START) && (in_action <= i2cmbe_pkg::ACT_READ);
      wait_nxt = wait_dec;
      if (wait_dec == 8'd0) begin
        unique case (phase_r)
          i2cmbe_pkg::PH_START_A: begin
            sda_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_START_B;
            wait_nxt  = phase_ld;
          end
          i2cmbe_pkg::PH_START_B: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          i2cmbe_pkg::PH_STOP_A: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_STOP_B;
            wait_nxt  = phase_ld;
          end
          i2cmbe_pkg::PH_STOP_B: begin
            sda_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_STOP_C;
            wait_nxt  = phase_ld;
          end
          i2cmbe_pkg::PH_STOP_C: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          i2cmbe_pkg::PH_WR_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_WR_HIGH;
            wait_nxt  = phase_ld;
          end
          i2cmbe_pkg::PH_WR_HIGH: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_inc;
            if (bit_inc < 4'(i2cmbe_pkg::BitsPerByte)) begin
              scl_nxt   = 1'b0;
              sda_nxt   = shift_r[6];
              phase_nxt = i2cmbe_pkg::PH_WR_LOW;
              wait_nxt  = setup_ld;
            end else begin
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b1;
              phase_nxt = i2cmbe_pkg::PH_WR_ACK;
              wait_nxt  = phase_ld;
            end
          end
          i2cmbe_pkg::PH_WR_ACK: begin
            nack_nxt  = in_sda_in;
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          i2cmbe_pkg::PH_RD_HIGH: begin
            shift_nxt   = {shift_r[6:0], in_sda_in};
            bit_idx_nxt = bit_inc;
            scl_nxt     = 1'b0;
            phase_nxt   = i2cmbe_pkg::PH_RD_LOW;
            wait_nxt    = phase_ld;
          end
          i2cmbe_pkg::PH_RD_LOW: begin
            scl_nxt  = 1'b1;
            wait_nxt = phase_ld;
            if (bit_idx_r < 4'(i2cmbe_pkg::BitsPerByte)) begin
              phase_nxt = i2cmbe_pkg::PH_RD_HIGH;
            end else begin
              sda_nxt   = ~ack_r;
              phase_nxt = i2cmbe_pkg::PH_RD_ACKH;
            end
          end
          i2cmbe_pkg::PH_RD_ACKH: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_RD_ACKL;
            wait_nxt  = phase_ld;
          end
          i2cmbe_pkg::PH_RD_ACKL: begin
            sda_nxt   = 1'b1;
            rx_nxt    = shift_r;
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE;
            wait_nxt  = 8'd0;
          end
        endcase
        if (phase_nxt == i2cmbe_pkg::PH_IDLE) begin
          wait_nxt = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmbe_pkg::PH_IDLE;
      bit_idx_r <= 4'd0;
      wait_r    <= 8'd0;
      shift_r   <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      ack_r     <= 1'b0;
      nack_r    <= 1'b0;
      rx_r      <= 8'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      wait_r    <= wait_nxt;
      shift_r   <= shift_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_r     <= ack_nxt;
      nack_r    <= nack_nxt;
      rx_r      <= rx_nxt;
    end
  end

  // Result of this tick, levels after the tick.
  i2cmbe_pkg::result_t res;

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != i2cmbe_pkg::PH_IDLE);
    res.done_res  = done;
    res.nack_seen = nack_nxt;
    res.read_byte = rx_nxt;
    res.rejected  = rej;
  end

  // Two-entry result buffer: head register feeding the port, skid entry behind.
  i2cmbe_pkg::result_t head_r;
  i2cmbe_pkg::result_t skid_r;
  logic                head_vld_r;
  logic                skid_vld_r;
  logic                pop;

  assign in_ready = ~skid_vld_r;
  assign pop      = head_vld_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (accept) begin
      if (head_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        head_vld_r <= 1'b1;
      end
    end else if (pop) begin
      head_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (accept) begin
      if (head_vld_r && !pop) begin
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end
  end

  assign out_valid     = head_vld_r;
  assign out_scl_level = head_r.scl_level;
  assign out_sda_level = head_r.sda_level;
  assign out_busy_res  = head_r.busy_res;
  assign out_done_res  = head_r.done_res;
  assign out_nack_seen = head_r.nack_seen;
  assign out_read_byte = head_r.read_byte;
  assign out_rejected  = head_r.rejected;

endmodule

/* hw/rtl/i2cmbe_checker.sv */
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2cmbe_pkg for port widths.
module i2cmbe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_busy_res,
  input logic                                out_done_res,
  input logic                                out_scl_level,
  input logic                                out_sda_level,
  input logic [7:0]                          out_read_byte,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [i2cmbe_pkg::CfgAddrWidth-1:0] paddr,
  input logic [i2cmbe_pkg::CfgDataWidth-1:0] pwdata,
  input logic [i2cmbe_pkg::CfgDataWidth-1:0] prdata
);

  // A completing command always leaves the engine idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done result still shows busy");

  // Input is only held off while a result is waiting.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl_level)
      && $stable(out_sda_level) && $stable(out_read_byte))
    else $error("stalled result changed");

  // A configuration write reads back at the same address.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && psel && penable && pwrite |=>
      (paddr[2] != $past(paddr[2])) || (prdata[7:0] == $past(pwdata[7:0])))
    else $error("configuration readback mismatch");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_scl_level (out_scl_level),
  .out_sda_level (out_sda_level),
  .out_read_byte (out_read_byte),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the I2C master byte engine top level.
// Depends on i2cmbe_pkg and i2c_master_byte_engine_unit; predicts every result item itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Actions 5 to 7 are not commands; the engine treats them as plain ticks.
  localparam logic [2:0] ActUnusedLo = 3'd5;
  localparam logic [2:0] ActUnusedHi = 3'd7;
  // Longest random gap or stall, in cycles.
  localparam int MaxIdle = 16;
  // Quiet cycles allowed after the last result before registers are touched.
  localparam int IdleGuard = 4;
  // Cycles with no accepted item on either channel before the run is abandoned.
  localparam int StallLimit = 2000;
  // Items in each random setting; the command in flight is always finished.
  localparam int ItemsPerSetting = 50;
  localparam int RandomSettings = 4;

  // Level that the bus sends back on SDA while a command runs.
  typedef enum logic [1:0] {
    SDA_LOW,
    SDA_HIGH,
    SDA_RANDOM
  } sda_pattern_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [2:0]                          in_action;
  logic [7:0]                          in_data_byte;
  logic                                in_send_ack;
  logic                                in_sda_in;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_scl_level;
  logic                                out_sda_level;
  logic                                out_busy_res;
  logic                                out_done_res;
  logic                                out_nack_seen;
  logic [7:0]                          out_read_byte;
  logic                                out_rejected;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [i2cmbe_pkg::CfgAddrWidth-1:0] paddr;
  logic [i2cmbe_pkg::CfgDataWidth-1:0] pwdata;
  logic [i2cmbe_pkg::CfgDataWidth-1:0] prdata;
  logic                                pready;

  i2c_master_byte_engine_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_send_ack   (in_send_ack),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_nack_seen (out_nack_seen),
    .out_read_byte (out_read_byte),
    .out_rejected  (out_rejected),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted engine state. It is advanced once per accepted input item, so at
  // any moment it describes the engine after every item sent so far. The
  // stimulus looks at it to decide whether the engine is idle or busy.
  // ---------------------------------------------------------------------------
  i2cmbe_pkg::phase_t eng_phase;
  logic [3:0] bit_cnt;
  logic [7:0] wait_cnt;
  logic [7:0] shreg;
  logic       scl_q;
  logic       sda_q;
  logic       ack_sel;
  logic       nack_q;
  logic [7:0] rx_byte;
  logic [7:0] setup_ticks;
  logic [7:0] phase_ticks;

  // Bus levels and flags predicted for each accepted tick, oldest first.
  i2cmbe_pkg::result_t tick_results[$];

  int  error_count;
  // When set, that side runs back to back without idle cycles for a while.
  bit  in_no_idle;
  bit  out_no_idle;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // A programmed wait of zero still holds the phase for one tick.
  function automatic void enter_phase(i2cmbe_pkg::phase_t nxt, logic [7:0] ticks);
    eng_phase = nxt;
    wait_cnt  = (ticks == 8'd0) ? 8'd1 : ticks;
  endfunction

  // Put the current MSB on SDA with SCL low, then hold it for the setup time.
  function automatic void drive_write_bit();
    scl_q = 1'b0;
    sda_q = shreg[7];
    enter_phase(i2cmbe_pkg::PH_WR_LOW, setup_ticks);
  endfunction

  // Leave the current phase once its wait has run out. Returns 1 when the
  // command completes on this tick.
  function automatic logic advance_phase(logic sda);
    logic done;
    done = 1'b0;
    case (eng_phase)
      i2cmbe_pkg::PH_START_A: begin
        sda_q = 1'b0;
        enter_phase(i2cmbe_pkg::PH_START_B, phase_ticks);
      end
      i2cmbe_pkg::PH_START_B: begin
        scl_q = 1'b0;
        done  = 1'b1;
      end
      i2cmbe_pkg::PH_STOP_A: begin
        scl_q = 1'b1;
        enter_phase(i2cmbe_pkg::PH_STOP_B, phase_ticks);
      end
      i2cmbe_pkg::PH_STOP_B: begin
        sda_q = 1'b1;
        enter_phase(i2cmbe_pkg::PH_STOP_C, phase_ticks);
      end
      i2cmbe_pkg::PH_STOP_C: begin
        done = 1'b1;
      end
      i2cmbe_pkg::PH_WR_LOW: begin
        scl_q = 1'b1;
        enter_phase(i2cmbe_pkg::PH_WR_HIGH, phase_ticks);
      end
      i2cmbe_pkg::PH_WR_HIGH: begin
        shreg   = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < i2cmbe_pkg::BitsPerByte) begin
          drive_write_bit();
        end else begin
          // Release SDA and raise SCL so the slave can answer.
          sda_q = 1'b1;
          scl_q = 1'b1;
          enter_phase(i2cmbe_pkg::PH_WR_ACK, phase_ticks);
        end
      end
      i2cmbe_pkg::PH_WR_ACK: begin
        nack_q = sda;
        scl_q  = 1'b0;
        done   = 1'b1;
      end
      i2cmbe_pkg::PH_RD_HIGH: begin
        shreg   = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        scl_q   = 1'b0;
        enter_phase(i2cmbe_pkg::PH_RD_LOW, phase_ticks);
      end
      i2cmbe_pkg::PH_RD_LOW: begin
        scl_q = 1'b1;
        if (bit_cnt < i2cmbe_pkg::BitsPerByte) begin
          enter_phase(i2cmbe_pkg::PH_RD_HIGH, phase_ticks);
        end else begin
          sda_q = ack_sel ? 1'b0 : 1'b1;
          enter_phase(i2cmbe_pkg::PH_RD_ACKH, phase_ticks);
        end
      end
      i2cmbe_pkg::PH_RD_ACKH: begin
        scl_q = 1'b0;
        enter_phase(i2cmbe_pkg::PH_RD_ACKL, phase_ticks);
      end
      i2cmbe_pkg::PH_RD_ACKL: begin
        sda_q   = 1'b1;
        rx_byte = shreg;
        done    = 1'b1;
      end
      default: ;
    endcase
    if (done || eng_phase == i2cmbe_pkg::PH_IDLE) begin
      eng_phase = i2cmbe_pkg::PH_IDLE;
      wait_cnt  = 8'd0;
    end
    return done;
  endfunction

  // Advance the predicted engine by one accepted tick and record the result.
  function automatic void step_engine(logic [2:0] act, logic [7:0] data, logic ack, logic sda);
    i2cmbe_pkg::result_t r;
    logic    done;
    logic    rej;
    done = 1'b0;
    rej  = 1'b0;
    if (eng_phase == i2cmbe_pkg::PH_IDLE) begin
      case (act)
        i2cmbe_pkg::ACT_START: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          enter_phase(i2cmbe_pkg::PH_START_A, phase_ticks);
        end
        i2cmbe_pkg::ACT_STOP: begin
          scl_q = 1'b0;
          sda_q = 1'b0;
          enter_phase(i2cmbe_pkg::PH_STOP_A, phase_ticks);
        end
        i2cmbe_pkg::ACT_WRITE: begin
          shreg   = data;
          bit_cnt = 4'd0;
          drive_write_bit();
        end
        i2cmbe_pkg::ACT_READ: begin
          shreg   = 8'd0;
          bit_cnt = 4'd0;
          ack_sel = ack;
          scl_q   = 1'b1;
          sda_q   = 1'b1;
          enter_phase(i2cmbe_pkg::PH_RD_HIGH, phase_ticks);
        end
        default: ;
      endcase
    end else begin
      // Any real command while busy is dropped, even on the completing tick.
      rej = (act >= i2cmbe_pkg::ACT_START && act <= i2cmbe_pkg::ACT_READ);
      if (wait_cnt > 8'd0) wait_cnt = wait_cnt - 8'd1;
      if (wait_cnt == 8'd0) done = advance_phase(sda);
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (eng_phase != i2cmbe_pkg::PH_IDLE);
    r.done_res  = done;
    r.nack_seen = nack_q;
    r.read_byte = rx_byte;
    r.rejected  = rej;
    tick_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The item is presented after a random gap and held until the
  // engine takes it. Valid stays high into the next item when that item has no
  // gap, so in_valid never gets two assignments in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [2:0] act, logic [7:0] data, logic ack, logic sda);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, MaxIdle);
    if ($urandom_range(0, 39) == 0) in_no_idle = !in_no_idle;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    in_send_ack  <= ack;
    in_sda_in    <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_engine(act, data, ack, sda);
  endtask

  function automatic logic sda_for(sda_pattern_t pattern);
    case (pattern)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Issue one command and keep ticking until the engine is idle again. With
  // flood set, every tick of the command also carries a random action, so
  // commands hit the engine in every phase, the completing tick included.
  task automatic run_command(logic [2:0] act, logic [7:0] data, logic ack,
                             sda_pattern_t pattern, bit flood);
    logic [2:0] tick_act;
    send_item(act, data, ack, sda_for(pattern));
    while (eng_phase != i2cmbe_pkg::PH_IDLE) begin
      tick_act = flood ? 3'($urandom_range(0, 7)) : 3'(i2cmbe_pkg::ACT_TICK);
      send_item(tick_act, 8'($urandom), 1'($urandom), sda_for(pattern));
    end
  endtask

  // Finish the command in flight, drop valid and wait until every predicted
  // result has come out, then wait out the IdleGuard quiet period.
  task automatic settle_engine();
    while (eng_phase != i2cmbe_pkg::PH_IDLE) begin
      send_item(i2cmbe_pkg::ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_results.size() != 0) @(posedge clk);
    repeat (IdleGuard) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, done at the edge where pready
  // is high. The trailing cycle keeps psel from being dropped and raised in
  // the same time step by back-to-back transfers.
  task automatic apb_access(logic wr, i2cmbe_pkg::cfg_idx_t idx, logic [7:0] value,
                            output logic [i2cmbe_pkg::CfgDataWidth-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(i2cmbe_pkg::CfgDataWidth - 8){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both waits while the engine is idle and read them back.
  task automatic program_waits(logic [7:0] setup_v, logic [7:0] phase_v);
    logic [i2cmbe_pkg::CfgDataWidth-1:0] rd;
    settle_engine();
    apb_access(1'b1, i2cmbe_pkg::CFG_DATA_SETUP_WAIT, setup_v, rd);
    setup_ticks = setup_v;
    apb_access(1'b1, i2cmbe_pkg::CFG_PHASE_WAIT, phase_v, rd);
    phase_ticks = phase_v;
    apb_access(1'b0, i2cmbe_pkg::CFG_DATA_SETUP_WAIT, 8'd0, rd);
    check_field("data_setup_wait readback", {24'd0, setup_v}, rd);
    apb_access(1'b0, i2cmbe_pkg::CFG_PHASE_WAIT, 8'd0, rd);
    check_field("phase_wait readback", {24'd0, phase_v}, rd);
  endtask

  // Mostly short waits keep commands short; a zero or a longer wait shows up
  // now and then.
  function automatic logic [7:0] pick_wait();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 9) return 8'($urandom_range(4, 10));
    return 8'($urandom_range(1, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Idle engine: plain ticks with extreme field values, and the unused actions,
  // which must behave as plain ticks and never be flagged.
  task automatic test_idle_ticks();
    send_item(i2cmbe_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    send_item(i2cmbe_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b1);
    for (int a = ActUnusedLo; a <= ActUnusedHi; a++) begin
      send_item(3'(a), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Start, one write and stop with the reset waits, then acknowledged and
  // unacknowledged writes and reads of all ones, all zeros and random bits
  // with ACK and NACK under short waits.
  task automatic test_commands();
    run_command(i2cmbe_pkg::ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_STOP, 8'($urandom), 1'b1, SDA_RANDOM, 1'b0);
    program_waits(8'd1, 8'd2);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(i2cmbe_pkg::ACT_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_command(i2cmbe_pkg::ACT_READ, 8'($urandom), 1'b1, SDA_RANDOM, 1'b0);
  endtask

  // Commands arriving while busy, in every phase and on the completing tick.
  task automatic test_busy_rejects();
    program_waits(8'd1, 8'd1);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b1);
    run_command(i2cmbe_pkg::ACT_READ, 8'($urandom), 1'b1, SDA_RANDOM, 1'b1);
    run_command(i2cmbe_pkg::ACT_START, 8'($urandom), 1'b0, SDA_RANDOM, 1'b1);
    run_command(i2cmbe_pkg::ACT_STOP, 8'($urandom), 1'b0, SDA_RANDOM, 1'b1);
  endtask

  // Waits of zero (one tick each), the largest setup wait with commands that
  // must not feel it, and a long phase wait on a start.
  task automatic test_wait_extremes();
    program_waits(8'd0, 8'd0);
    run_command(i2cmbe_pkg::ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_READ, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    program_waits(8'd255, 8'd1);
    run_command(i2cmbe_pkg::ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    run_command(i2cmbe_pkg::ACT_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    program_waits(8'd1, 8'd40);
    run_command(i2cmbe_pkg::ACT_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
  endtask

  // Random traffic over several wait settings. An idle engine mostly gets a
  // command, so back-to-back transactions dominate; a busy engine mostly gets
  // ticks with random SDA, plus some stray commands and unused actions.
  task automatic test_random_traffic();
    int         sent;
    int         roll;
    logic [2:0] act;
    for (int s = 0; s < RandomSettings; s++) begin
      program_waits(pick_wait(), pick_wait());
      sent = 0;
      while (sent < ItemsPerSetting || eng_phase != i2cmbe_pkg::PH_IDLE) begin
        roll = $urandom_range(0, 99);
        if (eng_phase == i2cmbe_pkg::PH_IDLE) begin
          if (roll < 80) act = 3'($urandom_range(i2cmbe_pkg::ACT_START, i2cmbe_pkg::ACT_READ));
          else if (roll < 90) act = i2cmbe_pkg::ACT_TICK;
          else act = 3'($urandom_range(ActUnusedLo, ActUnusedHi));
        end else begin
          if (roll < 90) act = i2cmbe_pkg::ACT_TICK;
          else if (roll < 96)
            act = 3'($urandom_range(i2cmbe_pkg::ACT_START, i2cmbe_pkg::ACT_READ));
          else act = 3'($urandom_range(ActUnusedLo, ActUnusedHi));
        end
        send_item(act, 8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls on out_ready, and a field-by-field check of
  // every accepted result item against the oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int      stall;
    i2cmbe_pkg::result_t exp_r;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_no_idle ? 0 : $urandom_range(0, MaxIdle);
      if ($urandom_range(0, 39) == 0) out_no_idle = !out_no_idle;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (tick_results.size() == 0) begin
        $error("result item arrived with no prediction waiting");
        error_count++;
      end else begin
        exp_r = tick_results.pop_front();
        check_field("scl_level", exp_r.scl_level, out_scl_level);
        check_field("sda_level", exp_r.sda_level, out_sda_level);
        check_field("busy_res", exp_r.busy_res, out_busy_res);
        check_field("done_res", exp_r.done_res, out_done_res);
        check_field("nack_seen", exp_r.nack_seen, out_nack_seen);
        check_field("read_byte", exp_r.read_byte, out_read_byte);
        check_field("rejected", exp_r.rejected, out_rejected);
      end
    end
  end

  // Ends a hung run: too many cycles in a row without any accepted item.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset once, then the tests in turn, then the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    error_count  = 0;
    in_no_idle   = 1'b0;
    out_no_idle  = 1'b0;
    // Predicted state after reset.
    eng_phase    = i2cmbe_pkg::PH_IDLE;
    bit_cnt      = 4'd0;
    wait_cnt     = 8'd0;
    shreg        = 8'd0;
    scl_q        = 1'b1;
    sda_q        = 1'b1;
    ack_sel      = 1'b0;
    nack_q       = 1'b0;
    rx_byte      = 8'd0;
    setup_ticks  = i2cmbe_pkg::ResetSetupWait;
    phase_ticks  = i2cmbe_pkg::ResetPhaseWait;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= i2cmbe_pkg::ACT_TICK;
    in_data_byte <= 8'd0;
    in_send_ack  <= 1'b0;
    in_sda_in    <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_commands();
    test_busy_rejects();
    test_wait_extremes();
    test_random_traffic();

    // Drain, then give a stray extra result time to show up.
    settle_engine();
    repeat (10) @(posedge clk);
    if (tick_results.size() != 0) begin
      $error("%0d predicted result items never arrived", tick_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
